// ===== design/dpt32_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpt32_pkg
// Shared types and constants for the 32-bit deterministic prime test.
// ----------------------------------------------------------------------------
package dpt32_pkg;

   localparam int NUM_WIDTH = 32;
   localparam int CNT_W     = $clog2(NUM_WIDTH + 1);
   localparam int BIT_W     = $clog2(NUM_WIDTH);
   localparam int BASE_W    = 2;

   localparam logic [BASE_W-1:0] LAST_BASE = 2'd2;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECOMP,
      S_BASE,
      S_REDUCE,
      S_POW_SQ,
      S_POW_SQ_W,
      S_POW_MUL,
      S_POW_MUL_W,
      S_CHECK,
      S_RLOOP,
      S_RSQ_W,
      S_RTEST,
      S_RESP
   } state_type;

   typedef struct packed {
      logic load;
      logic decomp_step;
      logic base_load;
      logic reduce_step;
      logic x_init;
      logic mul_start;
      logic mul_square;
      logic x_take;
      logic k_dec;
      logic r_init;
      logic r_inc;
      logic base_next;
      logic set_result;
      logic result_prime;
      logic rsp_load;
   } cmd_type;

   typedef struct packed {
      logic invalid;
      logic d_odd;
      logic a_ge_n;
      logic a_zero;
      logic mul_done;
      logic dbit;
      logic k_zero;
      logic x_one;
      logic x_nm1;
      logic r_lt_s;
      logic base_last;
      logic rsp_free;
   } status_type;

   function automatic logic [NUM_WIDTH-1:0] base_value(input logic [BASE_W-1:0] idx);
      logic [NUM_WIDTH-1:0] v;
      case (idx)
         2'd0:    v = NUM_WIDTH'(2);
         2'd1:    v = NUM_WIDTH'(7);
         default: v = NUM_WIDTH'(61);
      endcase
      return v;
   endfunction

endpackage

// ===== design/dpt32_modmul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpt32_modmul
// Bit-serial interleaved modular multiplier: one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module dpt32_modmul (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [dpt32_pkg::NUM_WIDTH-1:0] op_a,
   input  logic [dpt32_pkg::NUM_WIDTH-1:0] op_b,
   input  logic [dpt32_pkg::NUM_WIDTH-1:0] modulus,
   output logic                            done,
   output logic [dpt32_pkg::NUM_WIDTH-1:0] product
);
   import dpt32_pkg::*;

   logic [NUM_WIDTH-1:0] acc_ff, acc_in, mc_ff, mc_in, mp_ff, mp_in, m_ff, m_in;
   logic [BIT_W-1:0]     cnt_ff, cnt_in;
   logic                 busy_ff, busy_in, done_ff, done_in;
   logic [NUM_WIDTH:0]   dbl, dbl_r, sum;

   // operands below the modulus: each step needs two conditional subtracts
   always_comb begin
      dbl   = {acc_ff, 1'b0};
      dbl_r = (dbl >= {1'b0, m_ff}) ? dbl - {1'b0, m_ff} : dbl;
      sum   = dbl_r + (mp_ff[NUM_WIDTH-1] ? {1'b0, mc_ff} : '0);
      if (sum >= {1'b0, m_ff}) sum = sum - {1'b0, m_ff};
   end

   always_comb begin
      acc_in  = acc_ff;
      mc_in   = mc_ff;
      mp_in   = mp_ff;
      m_in    = m_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         acc_in  = '0;
         mc_in   = op_a;
         mp_in   = op_b;
         m_in    = modulus;
         cnt_in  = BIT_W'(NUM_WIDTH - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         acc_in = sum[NUM_WIDTH-1:0];
         mp_in  = {mp_ff[NUM_WIDTH-2:0], 1'b0};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      acc_ff <= acc_in;
      mc_ff  <= mc_in;
      mp_ff  <= mp_in;
      m_ff   <= m_in;
      cnt_ff <= cnt_in;
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule

// ===== design/dpt32_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpt32_datapath
// Operand registers, counters, shared modular multiplier and result beat.
// ----------------------------------------------------------------------------
module dpt32_datapath (
   input  logic                            clock,
   input  logic                            reset,
   input  dpt32_pkg::cmd_type              cmd,
   output dpt32_pkg::status_type           status,
   input  logic [31:0]                     req_candidate,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic                            rsp_is_prime,
   output logic                            rsp_input_invalid
);
   import dpt32_pkg::*;

   logic [NUM_WIDTH-1:0] n_ff, n_in, d_ff, d_in, a_ff, a_in, x_ff, x_in;
   logic [CNT_W-1:0]     s_ff, s_in, r_ff, r_in;
   logic [BIT_W-1:0]     k_ff, k_in;
   logic [BASE_W-1:0]    bi_ff, bi_in;
   logic                 inv_ff, inv_in, prime_ff, prime_in;
   logic                 rsp_valid_ff, rsp_valid_in, rsp_prime_ff, rsp_prime_in;
   logic                 rsp_inv_ff, rsp_inv_in;
   logic [NUM_WIDTH-1:0] cand, nm1, mul_b, product;
   logic                 mul_done;

   assign cand  = req_candidate[NUM_WIDTH-1:0];
   assign nm1   = n_ff - 1'b1;
   assign mul_b = cmd.mul_square ? x_ff : a_ff;

   dpt32_modmul u_modmul (
      .clock   (clock),
      .reset   (reset),
      .start   (cmd.mul_start),
      .op_a    (x_ff),
      .op_b    (mul_b),
      .modulus (n_ff),
      .done    (mul_done),
      .product (product)
   );

   always_comb begin
      n_in   = n_ff;
      d_in   = d_ff;
      a_in   = a_ff;
      x_in   = x_ff;
      s_in   = s_ff;
      r_in   = r_ff;
      k_in   = k_ff;
      bi_in  = bi_ff;
      inv_in = inv_ff;
      prime_in = prime_ff;
      if (cmd.load) begin
         n_in   = cand;
         inv_in = (cand < NUM_WIDTH'(3)) || !cand[0];
         d_in   = cand - 1'b1;
         s_in   = '0;
         bi_in  = '0;
      end
      if (cmd.decomp_step) begin
         d_in = {1'b0, d_ff[NUM_WIDTH-1:1]};
         s_in = s_ff + 1'b1;
      end
      if (cmd.base_load)   a_in = base_value(bi_ff);
      if (cmd.reduce_step) a_in = a_ff - n_ff;
      if (cmd.x_init) begin
         x_in = NUM_WIDTH'(1);
         k_in = BIT_W'(NUM_WIDTH - 1);
      end
      if (cmd.x_take)    x_in  = product;
      if (cmd.k_dec)     k_in  = k_ff - 1'b1;
      if (cmd.r_init)    r_in  = CNT_W'(1);
      if (cmd.r_inc)     r_in  = r_ff + 1'b1;
      if (cmd.base_next) bi_in = bi_ff + 1'b1;
      if (cmd.set_result) prime_in = cmd.result_prime;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_prime_in = rsp_prime_ff;
      rsp_inv_in   = rsp_inv_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_prime_in = prime_ff && !inv_ff;
         rsp_inv_in   = inv_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      n_ff         <= n_in;
      d_ff         <= d_in;
      a_ff         <= a_in;
      x_ff         <= x_in;
      s_ff         <= s_in;
      r_ff         <= r_in;
      k_ff         <= k_in;
      bi_ff        <= bi_in;
      inv_ff       <= inv_in;
      prime_ff     <= prime_in;
      rsp_prime_ff <= rsp_prime_in;
      rsp_inv_ff   <= rsp_inv_in;
   end

   always_comb begin
      status.invalid   = inv_ff;
      status.d_odd     = d_ff[0];
      status.a_ge_n    = a_ff >= n_ff;
      status.a_zero    = a_ff == '0;
      status.mul_done  = mul_done;
      status.dbit      = d_ff[k_ff];
      status.k_zero    = k_ff == '0;
      status.x_one     = x_ff == NUM_WIDTH'(1);
      status.x_nm1     = x_ff == nm1;
      status.r_lt_s    = r_ff < s_ff;
      status.base_last = bi_ff == LAST_BASE;
      status.rsp_free  = !rsp_valid_ff || !rsp_stall;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_is_prime      = rsp_prime_ff;
   assign rsp_input_invalid = rsp_inv_ff;

endmodule

// ===== design/dpt32_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpt32_ctrl
// Sequencer for decomposition, modular power and squaring chain per base.
// ----------------------------------------------------------------------------
module dpt32_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  dpt32_pkg::status_type status,
   output dpt32_pkg::cmd_type    cmd
);
   import dpt32_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = state_ff != S_IDLE;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_DECOMP;
            end
         end
         S_DECOMP: begin
            if (status.invalid) begin
               state_in = S_RESP;
            end else if (status.d_odd) begin
               state_in = S_BASE;
            end else begin
               cmd.decomp_step = 1'b1;
            end
         end
         S_BASE: begin
            cmd.base_load = 1'b1;
            state_in      = S_REDUCE;
         end
         S_REDUCE: begin
            if (status.a_ge_n) begin
               cmd.reduce_step = 1'b1;
            end else if (status.a_zero) begin
               // n divides the base: skip it
               if (status.base_last) begin
                  cmd.set_result   = 1'b1;
                  cmd.result_prime = 1'b1;
                  state_in         = S_RESP;
               end else begin
                  cmd.base_next = 1'b1;
                  state_in      = S_BASE;
               end
            end else begin
               cmd.x_init = 1'b1;
               state_in   = S_POW_SQ;
            end
         end
         S_POW_SQ: begin
            cmd.mul_start  = 1'b1;
            cmd.mul_square = 1'b1;
            state_in       = S_POW_SQ_W;
         end
         S_POW_SQ_W: begin
            if (status.mul_done) begin
               cmd.x_take = 1'b1;
               if (status.dbit) begin
                  state_in = S_POW_MUL;
               end else if (status.k_zero) begin
                  state_in = S_CHECK;
               end else begin
                  cmd.k_dec = 1'b1;
                  state_in  = S_POW_SQ;
               end
            end
         end
         S_POW_MUL: begin
            cmd.mul_start = 1'b1;
            state_in      = S_POW_MUL_W;
         end
         S_POW_MUL_W: begin
            if (status.mul_done) begin
               cmd.x_take = 1'b1;
               if (status.k_zero) begin
                  state_in = S_CHECK;
               end else begin
                  cmd.k_dec = 1'b1;
                  state_in  = S_POW_SQ;
               end
            end
         end
         S_CHECK: begin
            if (status.x_one || status.x_nm1) begin
               if (status.base_last) begin
                  cmd.set_result   = 1'b1;
                  cmd.result_prime = 1'b1;
                  state_in         = S_RESP;
               end else begin
                  cmd.base_next = 1'b1;
                  state_in      = S_BASE;
               end
            end else begin
               cmd.r_init = 1'b1;
               state_in   = S_RLOOP;
            end
         end
         S_RLOOP: begin
            if (status.r_lt_s) begin
               cmd.mul_start  = 1'b1;
               cmd.mul_square = 1'b1;
               state_in       = S_RSQ_W;
            end else begin
               cmd.set_result = 1'b1;
               state_in       = S_RESP;
            end
         end
         S_RSQ_W: begin
            if (status.mul_done) begin
               cmd.x_take = 1'b1;
               cmd.r_inc  = 1'b1;
               state_in   = S_RTEST;
            end
         end
         S_RTEST: begin
            if (status.x_nm1) begin
               if (status.base_last) begin
                  cmd.set_result   = 1'b1;
                  cmd.result_prime = 1'b1;
                  state_in         = S_RESP;
               end else begin
                  cmd.base_next = 1'b1;
                  state_in      = S_BASE;
               end
            end else begin
               state_in = S_RLOOP;
            end
         end
         S_RESP: begin
            if (status.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

// ===== design/deterministic_prime_test_32_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deterministic_prime_test_32_core
// Miller-Rabin primality test with bases 2, 7 and 61 for 32-bit numbers.
// ----------------------------------------------------------------------------
// Usage:
//   req channel carries one candidate per beat; rsp channel returns one beat
//   with is_prime and input_invalid for every request, in order.
//   One item is in flight at a time; req_stall is high from acceptance until
//   the result is moved into the output register.
//   Even or small candidates pass from acceptance through S_DECOMP and
//   S_RESP into the output register. Otherwise the shared bit-serial modular
//   multiplier sets the pace. A base costs 32 squarings plus one multiply per
//   set exponent bit, plus up to s-1 extra squarings; a composite rejected
//   by base 2 ends after one base.
//   The output register holds a finished beat while rsp_stall is high; the
//   next request is accepted meanwhile, and its result waits until the
//   register frees.
//   Reset (synchronous) returns the sequencer to idle and drops rsp_valid.
// ----------------------------------------------------------------------------
module deterministic_prime_test_32_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_candidate,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_is_prime,
   output logic        rsp_input_invalid
);
   import dpt32_pkg::*;

   cmd_type    cmd;
   status_type status;

   dpt32_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   dpt32_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_candidate     (req_candidate),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_is_prime      (rsp_is_prime),
      .rsp_input_invalid (rsp_input_invalid)
   );

endmodule

// ===== design/dpt32_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpt32_checker
// Port-level checks on the prime test core, bound to the top level.
// ----------------------------------------------------------------------------
module dpt32_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_stall,
   input logic rsp_valid,
   input logic rsp_stall,
   input logic rsp_is_prime,
   input logic rsp_input_invalid
);

   // a held result beat stays up
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("rsp beat dropped while stalled");

   a_inv_not_prime: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_input_invalid |-> !rsp_is_prime)
      else $error("invalid input reported prime");

   // one item at a time: busy right after acceptance
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second request taken while busy");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid set after reset");

endmodule

bind deterministic_prime_test_32_core dpt32_checker u_dpt32_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_stall         (req_stall),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_is_prime      (rsp_is_prime),
   .rsp_input_invalid (rsp_input_invalid)
);
